// ===== hw/rtl/spom_pkg.sv =====
package spom_pkg;

    localparam int MAX_LEN = 32;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 8;

    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_RUN         = 2'd2
    } op_t;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CHAR_W-1:0] char_t;

endpackage

// ===== hw/rtl/suffix_prefix_overlap_merge.sv =====
// Suffix/prefix overlap merger. Transfers with tuser = load-first or load-second append
// tdata to one of two MAX_LEN-character stores, one transfer per cycle; characters beyond
// MAX_LEN are dropped and flagged as overflow. A run transfer searches overlap lengths from
// the longest candidate down, comparing one character pair per cycle through the two store
// RAM read ports. Emission then reads each character in two steps (RAM read, output
// register), waiting for the sink to take the previous character. The input stays stalled
// from the run transfer until the last result transfer, after which both lengths and the
// overflow flag clear.
module suffix_prefix_overlap_merge
    import spom_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_out
    output logic [1:0]  m_tuser,   // [0] found, [1] overflow
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT_ADDR,
        ST_EMIT_DATA
    } state_t;

    typedef enum logic {
        ST_OUT_EMPTY,
        ST_OUT_FULL
    } ostate_t;

    state_t  state_reg, state_next;
    ostate_t ost_reg, ost_next;
    cnt_t    first_cnt_reg, first_cnt_next;
    cnt_t    second_cnt_reg, second_cnt_next;
    logic    ovf_reg, ovf_next;
    addr_t   d_reg, d_next;
    addr_t   k_reg, k_next;
    logic    cmp_vld_reg, cmp_vld_next;
    logic    cmp_last_reg, cmp_last_next;
    addr_t   idx_reg, idx_next;
    logic    phase_reg, phase_next;
    char_t   out_char_reg, out_char_next;
    logic    out_found_reg, out_found_next;
    logic    out_last_reg, out_last_next;

    logic    s_xfer, m_xfer;
    op_t     op;
    logic    first_we, second_we;
    addr_t   first_raddr, second_raddr;
    char_t   first_rdata, second_rdata;
    cnt_t    min_cnt, sec_pos, head, idx_ext;
    logic    is_last;

    assign s_tready = (state_reg == ST_IDLE) && (ost_reg == ST_OUT_EMPTY);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = (ost_reg == ST_OUT_FULL);
    assign m_xfer   = m_tvalid && m_tready;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = {ovf_reg, out_found_reg};
    assign m_tlast  = out_last_reg;
    assign op       = op_t'(s_tuser);

    assign min_cnt  = (first_cnt_reg < second_cnt_reg) ? first_cnt_reg : second_cnt_reg;
    assign sec_pos  = second_cnt_reg - cnt_t'(d_reg) + cnt_t'(k_reg);
    assign head     = second_cnt_reg - cnt_t'(d_reg);
    assign idx_ext  = cnt_t'(idx_reg);
    assign is_last  = phase_reg && (idx_ext + cnt_t'(1) == head);

    // Loads only happen while idle and reads only during a run, so no forwarding is needed.
    assign first_we     = s_xfer && (op == OP_LOAD_FIRST) && (first_cnt_reg < cnt_t'(MAX_LEN));
    assign second_we    = s_xfer && (op == OP_LOAD_SECOND) && (second_cnt_reg < cnt_t'(MAX_LEN));
    assign first_raddr  = (state_reg == ST_SEARCH) ? k_reg : idx_reg;
    assign second_raddr = (state_reg == ST_SEARCH) ? sec_pos[ADDR_W-1:0] : idx_reg;

    spom_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_ram (
        .aclk  (aclk),
        .we    (first_we),
        .waddr (first_cnt_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    spom_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_ram (
        .aclk  (aclk),
        .we    (second_we),
        .waddr (second_cnt_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (second_raddr),
        .rdata (second_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        ost_next        = ost_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        ovf_next        = ovf_reg;
        d_next          = d_reg;
        k_next          = k_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_last_next   = cmp_last_reg;
        idx_next        = idx_reg;
        phase_next      = phase_reg;
        out_char_next   = out_char_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;

        if (m_xfer) begin
            ost_next = ST_OUT_EMPTY;
            if (out_last_reg) begin
                first_cnt_next  = '0;
                second_cnt_next = '0;
                ovf_next        = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (op)
                        OP_LOAD_FIRST: begin
                            if (first_we) begin
                                first_cnt_next = first_cnt_reg + cnt_t'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_LOAD_SECOND: begin
                            if (second_we) begin
                                second_cnt_next = second_cnt_reg + cnt_t'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_RUN: begin
                            if (min_cnt < cnt_t'(2)) begin
                                ost_next       = ST_OUT_FULL;
                                out_char_next  = '0;
                                out_found_next = 1'b0;
                                out_last_next  = 1'b1;
                            end else begin
                                state_next   = ST_SEARCH;
                                d_next       = addr_t'(min_cnt - cnt_t'(1));
                                k_next       = '0;
                                cmp_vld_next = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (cmp_vld_reg && (first_rdata != second_rdata)) begin
                    cmp_vld_next = 1'b0;
                    k_next       = '0;
                    if (d_reg == addr_t'(1)) begin
                        state_next     = ST_IDLE;
                        ost_next       = ST_OUT_FULL;
                        out_char_next  = '0;
                        out_found_next = 1'b0;
                        out_last_next  = 1'b1;
                    end else begin
                        d_next = d_reg - addr_t'(1);
                    end
                end else if (cmp_vld_reg && cmp_last_reg) begin
                    cmp_vld_next = 1'b0;
                    state_next   = ST_EMIT_ADDR;
                    idx_next     = d_reg;
                    phase_next   = 1'b0;
                end else begin
                    cmp_vld_next  = 1'b1;
                    cmp_last_next = (k_reg == d_reg - addr_t'(1));
                    k_next        = k_reg + addr_t'(1);
                end
            end
            ST_EMIT_ADDR: begin
                if (ost_reg == ST_OUT_EMPTY || m_xfer) begin
                    state_next = ST_EMIT_DATA;
                end
            end
            ST_EMIT_DATA: begin
                ost_next       = ST_OUT_FULL;
                out_char_next  = phase_reg ? second_rdata : first_rdata;
                out_found_next = 1'b1;
                out_last_next  = is_last;
                state_next     = is_last ? ST_IDLE : ST_EMIT_ADDR;
                if (!phase_reg && (idx_ext + cnt_t'(1) == first_cnt_reg)) begin
                    phase_next = 1'b1;
                    idx_next   = '0;
                end else begin
                    idx_next = idx_reg + addr_t'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ost_reg        <= ST_OUT_EMPTY;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            cmp_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ost_reg        <= ost_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            ovf_reg        <= ovf_next;
            cmp_vld_reg    <= cmp_vld_next;
        end
        d_reg         <= d_next;
        k_reg         <= k_next;
        cmp_last_reg  <= cmp_last_next;
        idx_reg       <= idx_next;
        phase_reg     <= phase_next;
        out_char_reg  <= out_char_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_cnt_reg <= cnt_t'(MAX_LEN)) && (second_cnt_reg <= cnt_t'(MAX_LEN)))
        else $error("string length beyond capacity");

    a_clear_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |=> (first_cnt_reg == '0) && (second_cnt_reg == '0) && !ovf_reg)
        else $error("lengths not cleared after final transfer");

    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH && state_next == ST_SEARCH && cmp_vld_next)
            |-> (k_reg < d_reg))
        else $error("compare index beyond overlap length");
`endif

endmodule

// ===== hw/rtl/spom_ram.sv =====
module spom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/spom_merge_checker.sv =====
`timescale 1ns / 100ps

module spom_merge_checker
    import spom_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic [1:0] s_tuser,   // [1:0] operation
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] char_out
    input  logic [1:0] m_tuser,   // [0] found, [1] overflow
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending,
    output int         run_count,
    output int         merged_runs,
    output int         overflow_runs,
    output int         beats_checked
);

    typedef struct packed {
        char_t ch;
        logic  found;
        logic  overflow;
        logic  last;
    } merge_beat_t;

    char_t       strings [2][MAX_LEN];
    int          lengths [2];
    logic        dropped;
    merge_beat_t merge_q [$];

    function automatic int longest_overlap();
        int best;
        bit same;
        best = 0;
        for (int d = 1; d < lengths[0] && d < lengths[1]; d++) begin
            same = 1'b1;
            for (int k = 0; k < d; k++) begin
                if (strings[0][k] != strings[1][lengths[1] - d + k]) same = 1'b0;
            end
            if (same) best = d;
        end
        return best;
    endfunction

    task automatic append_char(input int sel, input char_t ch);
        if (lengths[sel] < MAX_LEN) begin
            strings[sel][lengths[sel]] = ch;
            lengths[sel]++;
        end else begin
            dropped = 1'b1;
        end
    endtask

    task automatic predict_merge();
        int best;
        best = longest_overlap();
        run_count++;
        if (dropped) overflow_runs++;
        if (best == 0) begin
            merge_q.push_back(merge_beat_t'{8'h00, 1'b0, dropped, 1'b1});
        end else begin
            merged_runs++;
            for (int i = best; i < lengths[0]; i++)
                merge_q.push_back(merge_beat_t'{strings[0][i], 1'b1, dropped, 1'b0});
            for (int i = 0; i < lengths[1] - best; i++)
                merge_q.push_back(merge_beat_t'{strings[1][i], 1'b1, dropped, 1'b0});
            merge_q[merge_q.size() - 1].last = 1'b1;
        end
        lengths[0] = 0;
        lengths[1] = 0;
        dropped    = 1'b0;
    endtask

    task automatic check_beat();
        merge_beat_t want;
        if (merge_q.size() == 0) begin
            $error("result transfer with nothing expected: char_out %0h", m_tdata);
            fail_count++;
        end else begin
            want = merge_q.pop_front();
            beats_checked++;
            if (m_tdata !== want.ch) begin
                $error("char_out: expected %0h, got %0h", want.ch, m_tdata);
                fail_count++;
            end
            if (m_tuser[0] !== want.found) begin
                $error("found: expected %0b, got %0b", want.found, m_tuser[0]);
                fail_count++;
            end
            if (m_tuser[1] !== want.overflow) begin
                $error("overflow: expected %0b, got %0b", want.overflow, m_tuser[1]);
                fail_count++;
            end
            if (m_tlast !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, m_tlast);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            lengths[0] = 0;
            lengths[1] = 0;
            dropped    = 1'b0;
            merge_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_LOAD_FIRST:  append_char(0, s_tdata);
                    OP_LOAD_SECOND: append_char(1, s_tdata);
                    OP_RUN:         predict_merge();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) check_beat();
        end
        pending <= merge_q.size();
    end

endmodule

// ===== test/suffix_prefix_overlap_merge_tb.sv =====
`timescale 1ns / 100ps

module suffix_prefix_overlap_merge_tb;
    import spom_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 130;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 64;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] char_in
    logic [1:0] s_tuser  = '0;   // [1:0] operation
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [7:0] char_out
    logic [1:0] m_tuser;         // [0] found, [1] overflow
    logic       m_tlast;

    int send_idle_pct = 34;
    int recv_idle_pct = 46;
    int items_sent    = 0;
    int stall_cycles  = 0;
    int random_start;

    int fail_count;
    int pending;
    int run_count;
    int merged_runs;
    int overflow_runs;
    int beats_checked;

    always #5 aclk = ~aclk;

    suffix_prefix_overlap_merge i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    spom_merge_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .run_count     (run_count),
        .merged_runs   (merged_runs),
        .overflow_runs (overflow_runs),
        .beats_checked (beats_checked)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[suffix_prefix_overlap_merge] ERROR");
            $finish;
        end
    end

    function automatic char_t pick_char();
        if ($urandom_range(0, 1)) return char_t'($urandom_range(8'h61, 8'h63));
        return char_t'($urandom_range(0, 255));
    endfunction

    // returns right after the rising edge that completes the transfer
    task automatic send_item(input logic [1:0] op, input char_t ch);
        if (items_sent < 61) begin
            send_idle_pct = 34;
            recv_idle_pct = 46;
        end else if (items_sent < 122) begin
            send_idle_pct = 46;
            recv_idle_pct = 34;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic send_pair_and_run();
        char_t first_str[$];
        char_t second_str[$];
        int    first_len;
        int    second_len;
        int    ov;
        int    n1;
        int    n2;
        if ($urandom_range(0, 7) == 0) begin
            first_len  = $urandom_range(28, 34);
            second_len = $urandom_range(28, 34);
        end else begin
            first_len  = $urandom_range(0, 7);
            second_len = $urandom_range(0, 7);
        end
        for (int i = 0; i < first_len; i++) first_str.push_back(pick_char());
        ov = 0;
        if (first_len > 0 && second_len > 0 && $urandom_range(0, 9) < 7)
            ov = $urandom_range(1, (first_len < second_len) ? first_len : second_len);
        for (int i = 0; i < second_len - ov; i++) second_str.push_back(pick_char());
        for (int i = 0; i < ov; i++) second_str.push_back(first_str[i]);
        n1 = 0;
        n2 = 0;
        while (n1 < first_len || n2 < second_len) begin
            if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, pick_char());
            if (n2 >= second_len || (n1 < first_len && $urandom_range(0, 1))) begin
                send_item(OP_LOAD_FIRST, first_str[n1]);
                n1++;
            end else begin
                send_item(OP_LOAD_SECOND, second_str[n2]);
                n2++;
            end
        end
        send_item(OP_RUN, pick_char());
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) send_item(2'($urandom_range(0, 3)), pick_char());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty strings, then an ignored code
        send_item(OP_RUN, 8'h00);
        send_item(OP_UNUSED, 8'hFF);
        // one-char overlap with zero and all-ones characters
        send_item(OP_LOAD_FIRST, 8'h00);
        send_item(OP_LOAD_FIRST, 8'hFF);
        send_item(OP_LOAD_SECOND, 8'h80);
        send_item(OP_LOAD_SECOND, 8'h00);
        send_item(OP_RUN, 8'hFF);
        // single-char first string: nothing found
        send_item(OP_LOAD_FIRST, 8'h41);
        send_item(OP_LOAD_SECOND, 8'h41);
        send_item(OP_LOAD_SECOND, 8'h41);
        send_item(OP_RUN, 8'h00);
        // no matching characters
        send_item(OP_LOAD_FIRST, 8'h01);
        send_item(OP_LOAD_FIRST, 8'h02);
        send_item(OP_LOAD_FIRST, 8'h03);
        send_item(OP_LOAD_SECOND, 8'h04);
        send_item(OP_LOAD_SECOND, 8'h05);
        send_item(OP_RUN, 8'h00);
        // interleaved loads with an ignored code in between
        send_item(OP_LOAD_FIRST, 8'h7F);
        send_item(OP_LOAD_SECOND, 8'h01);
        send_item(OP_UNUSED, 8'h55);
        send_item(OP_LOAD_FIRST, 8'h01);
        send_item(OP_LOAD_SECOND, 8'h7F);
        send_item(OP_RUN, 8'hAA);

        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) send_pair_and_run();
            else send_noise();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d runs: %0d merged, %0d with dropped characters",
                 run_count, merged_runs, overflow_runs);
        $display("%0d input transfers, %0d result transfers checked",
                 items_sent, beats_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("[suffix_prefix_overlap_merge] OK");
        end else begin
            $display("[suffix_prefix_overlap_merge] ERROR");
        end
        $finish;
    end

endmodule
